>>> rtl/core/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types, widths and constant tables
// Widths of the fixed-point datapath, register index codes, the side record
// that travels with each item, and the log2 and exp2 constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int MAX_CHILDREN_DEF = 64;

  // port field widths
  localparam int N_W   = 7;   // child count
  localparam int D_W   = 8;   // tree depth
  localparam int L_W   = 20;  // leaf count
  localparam int R_W   = 16;  // request fraction Q0.16
  localparam int S_W   = 6;   // split count
  localparam int IDX_W = 2;   // config register index
  localparam int CFG_W = 20;  // config write data

  // datapath widths
  localparam int LG_W  = 21;  // log2(L) Q16.16, integer part below 20
  localparam int LN_W  = 19;  // log2(n) Q16.16, n below 128
  localparam int RAT_W = 21;  // log ratio Q16.16
  localparam int DZ_W  = 10;  // n-1-d, signed
  localparam int Z_W   = 27;  // z, signed Q16.16
  localparam int MAG_W = 25;  // |z|
  localparam int T_W   = 26;  // |z| * log2(e)
  localparam int P_W   = 31;  // 2^-t in Q1.30
  localparam int C_W   = 30;  // exp2 step constants
  localparam int DEN_W = 32;  // 2^30 + e
  localparam int Q_W   = 17;  // 1/(1+e) with 16 fraction bits
  localparam int FRAC_STEPS = 16;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // config register indexes
  localparam logic [IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_LEAVES  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_REQFRAC = 2'd2;

  // what rides along with each item through the pipeline
  typedef struct packed {
    logic [N_W-1:0]         n;     // clamped child count
    logic signed [DZ_W-1:0] dz;    // n-1-d
    logic                   zneg;  // z below zero
    logic                   byp;   // result known at the input
    logic [S_W-1:0]         bval;  // that result
  } ssc_side_t;

  typedef logic [127:0][LN_W-1:0]       ln_tab_t;
  typedef logic [FRAC_STEPS-1:0][C_W-1:0] expc_tab_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned w;
    r = 64'd0;
    b = 64'd1 << 62;
    w = v;
    while (b > w) b = b >> 2;
    while (b != 64'd0) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 in Q16.16 by repeated squaring, elaboration only
  function automatic logic [LN_W-1:0] log2_q16_c(input int unsigned x);
    int unsigned m;
    longint unsigned y;
    int unsigned frac;
    m = 0;
    frac = 0;
    while (m < 30 && (x >> (m + 1)) != 0) m++;
    y = longint'(x) << (30 - m);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return LN_W'((m << 16) | frac);
  endfunction

  function automatic ln_tab_t mk_ln_tab();
    ln_tab_t tab;
    for (int i = 0; i < 128; i++) begin
      // entries for no child or one child are never used; keep them nonzero
      tab[i] = (i < 2) ? LN_W'(65536) : log2_q16_c(i);
    end
    return tab;
  endfunction

  function automatic expc_tab_t mk_expc_tab();
    expc_tab_t tab;
    longint unsigned c;
    c = isqrt64(64'd1 << 59);
    for (int k = 0; k < FRAC_STEPS; k++) begin
      tab[k] = C_W'(c);
      c = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam ln_tab_t   LOG2N_TAB = mk_ln_tab();
  localparam expc_tab_t EXP_C     = mk_expc_tab();

endpackage

`default_nettype wire

>>> rtl/core/ssc_in_if.sv
// ----------------------------------------------------------------------------
// ssc_in_if: input item channel
// Valid/ready channel carrying child count and tree depth.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_in_if import ssc_pkg::*;;
  logic           valid;
  logic           ready;
  logic [N_W-1:0] child_count;
  logic [D_W-1:0] tree_depth;

  modport source (output valid, output child_count, output tree_depth, input ready);
  modport sink   (input valid, input child_count, input tree_depth, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ssc_out_if.sv
// ----------------------------------------------------------------------------
// ssc_out_if: result item channel
// Valid/ready channel carrying the split count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_out_if import ssc_pkg::*;;
  logic           valid;
  logic           ready;
  logic [S_W-1:0] split_count;

  modport source (output valid, output split_count, input ready);
  modport sink   (input valid, input split_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ssc_cfg_if.sv
// ----------------------------------------------------------------------------
// ssc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssc_cfg_if import ssc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ssc_log2.sv
// ----------------------------------------------------------------------------
// ssc_log2: pipelined log2 of the leaf count
// One stage normalizes, then one squaring per stage yields a fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_log2 import ssc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [L_W-1:0]  x,
  input  wire ssc_side_t       in_side,
  output logic                 out_valid,
  output logic [LG_W-1:0]      log_val,
  output ssc_side_t            out_side
);

  localparam int ST = FRAC_STEPS + 1;

  logic [ST-1:0]         vld_r;
  logic [P_W-1:0]        y_r    [ST];
  logic [P_W-1:0]        y_nxt  [ST];
  logic [4:0]            m_r    [ST];
  logic [FRAC_STEPS-1:0] frac_r [ST];
  logic [FRAC_STEPS-1:0] frac_nxt [ST];
  ssc_side_t             side_r [ST];

  // normalize and square
  always_comb begin
    logic [4:0]     m;
    logic [2*P_W-1:0] sq;
    logic [P_W:0]   y2;
    m = '0;
    for (int i = 0; i < L_W; i++) begin
      if (x[i]) m = 5'(i);
    end
    y_nxt[0]    = P_W'({11'd0, x}) << (5'd30 - m);
    frac_nxt[0] = '0;
    for (int k = 1; k < ST; k++) begin
      sq = y_r[k-1] * y_r[k-1];
      y2 = sq[2*P_W-1:30];
      y_nxt[k]    = y2[P_W] ? y2[P_W:1] : y2[P_W-1:0];
      frac_nxt[k] = {frac_r[k-1][FRAC_STEPS-2:0], y2[P_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ST; k++) begin
        y_r[k]    <= y_nxt[k];
        frac_r[k] <= frac_nxt[k];
      end
      side_r[0] <= in_side;
      for (int i = 0; i < L_W; i++) begin
        if (x[i]) m_r[0] <= 5'(i);
      end
      if (x == '0) m_r[0] <= '0;
      for (int k = 1; k < ST; k++) begin
        m_r[k]    <= m_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[ST-1];
  assign log_val   = {m_r[ST-1], frac_r[ST-1]};
  assign out_side  = side_r[ST-1];

endmodule

`default_nettype wire

>>> rtl/core/ssc_div.sv
// ----------------------------------------------------------------------------
// ssc_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_div import ssc_pkg::*; #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 19,
  parameter int QUO_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire ssc_side_t        in_side,
  output logic                  out_valid,
  output logic [QUO_W-1:0]      quo,
  output ssc_side_t             out_side
);

  localparam int HI_W = NUM_W - QUO_W;

  logic [QUO_W-1:0] vld_r;
  logic [DEN_W-1:0] rem_r   [QUO_W];
  logic [DEN_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] low_r   [QUO_W];
  logic [QUO_W-1:0] low_nxt [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];
  logic [DEN_W-1:0] den_r   [QUO_W];
  ssc_side_t        side_r  [QUO_W];

  // compare and subtract, one bit per stage
  always_comb begin
    logic [DEN_W-1:0] rc;
    logic [DEN_W-1:0] dc;
    logic [QUO_W-1:0] lc;
    logic [QUO_W-1:0] qc;
    logic [DEN_W:0]   tr;
    logic             fit;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        rc = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
        dc = den;
        lc = num[QUO_W-1:0];
        qc = '0;
      end else begin
        rc = rem_r[k-1];
        dc = den_r[k-1];
        lc = low_r[k-1];
        qc = quo_r[k-1];
      end
      tr  = {rc, lc[QUO_W-1]};
      fit = tr >= {1'b0, dc};
      rem_nxt[k] = fit ? DEN_W'(tr - {1'b0, dc}) : DEN_W'(tr);
      low_nxt[k] = lc << 1;
      quo_nxt[k] = {qc[QUO_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      den_r[0]  <= den;
      side_r[0] <= in_side;
      for (int k = 1; k < QUO_W; k++) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/core/ssc_exp2.sv
// ----------------------------------------------------------------------------
// ssc_exp2: pipelined 2^-t
// One constant multiply per fraction bit, then a shift by the integer part.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_exp2 import ssc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [T_W-1:0]  t,
  input  wire ssc_side_t       in_side,
  output logic                 out_valid,
  output logic [P_W-1:0]       e,
  output ssc_side_t            out_side
);

  localparam int ST = FRAC_STEPS + 1;

  logic [ST-1:0]  vld_r;
  logic [P_W-1:0] p_r   [FRAC_STEPS];
  logic [P_W-1:0] p_nxt [FRAC_STEPS];
  logic [T_W-1:0] t_r   [FRAC_STEPS];
  ssc_side_t      side_r [ST];
  logic [P_W-1:0] e_r;
  logic [P_W-1:0] e_nxt;

  // conditional multiply per fraction bit, then the integer shift
  always_comb begin
    logic [P_W-1:0]     pc;
    logic [T_W-1:0]     tc;
    logic [P_W+C_W-1:0] prod;
    logic [T_W-17:0]    ip;
    for (int k = 0; k < FRAC_STEPS; k++) begin
      pc = (k == 0) ? P_W'(31'h4000_0000) : p_r[k-1];
      tc = (k == 0) ? t : t_r[k-1];
      prod = pc * EXP_C[k];
      p_nxt[k] = tc[FRAC_STEPS-1-k] ? prod[P_W+C_W-1:30] : pc;
    end
    ip = t_r[FRAC_STEPS-1][T_W-1:16];
    e_nxt = (ip >= (T_W-16)'(31)) ? '0 : (p_r[FRAC_STEPS-1] >> ip[4:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FRAC_STEPS; k++) begin
        p_r[k] <= p_nxt[k];
      end
      t_r[0]    <= t;
      side_r[0] <= in_side;
      for (int k = 1; k < FRAC_STEPS; k++) begin
        t_r[k] <= t_r[k-1];
      end
      for (int k = 1; k < ST; k++) begin
        side_r[k] <= side_r[k-1];
      end
      e_r <= e_nxt;
    end
  end

  assign out_valid = vld_r[ST-1];
  assign e         = e_r;
  assign out_side  = side_r[ST-1];

endmodule

`default_nettype wire

>>> rtl/core/sigmoid_split_count.sv
// ----------------------------------------------------------------------------
// sigmoid_split_count: split decision for a recursive task tree
// Computes how many of a node's children to hand out for remote work.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one split_count per item, in order. The result of an item passes
// through a chain of 77 register stages: the input register, a 17-stage
// log2 of the leaf count, a 21-stage divider for the log ratio, three
// multiply stages for z and |z|*log2(e), a 17-stage exp2, a 17-stage divider
// for 1/(1+e), and the output register. A stalled output holds the whole
// pipeline; no item is lost or repeated. Configuration writes are taken in
// any cycle; they apply only to items accepted once the block has drained if
// the user writes while it is drained, as the block does not enforce this.
`default_nettype none

module sigmoid_split_count import ssc_pkg::*; #(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ssc_in_if.sink     in_ch,
  ssc_out_if.source  out_ch,
  ssc_cfg_if.sink    cfg_ch
);

  logic             en;
  logic             policy_r;
  logic [L_W-1:0]   leaf_r;
  logic [R_W-1:0]   rfrac_r;

  logic             s0_vld_r;
  ssc_side_t        s0_side_r;
  ssc_side_t        s0_side_nxt;

  logic             lg_vld;
  logic [LG_W-1:0]  lg_val;
  ssc_side_t        lg_side;

  logic             d1_vld;
  logic [RAT_W-1:0] ratio;
  ssc_side_t        d1_side;

  logic             mul_vld_r;
  logic [RAT_W-1:0] sun_r;
  ssc_side_t        mul_side_r;

  logic             z_vld_r;
  logic [MAG_W-1:0] mag_r;
  ssc_side_t        z_side_r;
  ssc_side_t        z_side_nxt;
  logic [MAG_W-1:0] mag_nxt;

  logic             t_vld_r;
  logic [T_W-1:0]   t_r;
  ssc_side_t        t_side_r;

  logic             ex_vld;
  logic [P_W-1:0]   ex_e;
  ssc_side_t        ex_side;

  logic [DEN_W-1:0] den2;
  logic [46:0]      num2;
  logic             d2_vld;
  logic [Q_W-1:0]   q2;
  ssc_side_t        d2_side;

  logic             out_vld_r;
  logic [S_W-1:0]   out_split_r;
  logic [S_W-1:0]   out_split_nxt;

  // the whole pipeline advances unless a result waits
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // config registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      leaf_r   <= L_W'(1);
      rfrac_r  <= R_W'(32768);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_POLICY:  policy_r <= cfg_ch.data[0];
        CFG_LEAVES:  leaf_r   <= cfg_ch.data[L_W-1:0];
        CFG_REQFRAC: rfrac_r  <= cfg_ch.data[R_W-1:0];
        default:     ;
      endcase
    end
  end

  // clamp n and settle the trivial cases at the input
  always_comb begin
    logic [N_W-1:0] n_c;
    n_c = (int'(in_ch.child_count) > MAX_CHILDREN) ? N_W'(MAX_CHILDREN)
                                                   : in_ch.child_count;
    s0_side_nxt.n    = n_c;
    s0_side_nxt.dz   = $signed({3'b0, n_c}) - DZ_W'(1) - $signed({2'b0, in_ch.tree_depth});
    s0_side_nxt.zneg = 1'b0;
    s0_side_nxt.byp  = (n_c <= N_W'(1)) || policy_r;
    if (n_c <= N_W'(1)) begin
      s0_side_nxt.bval = '0;
    end else if ((n_c - N_W'(1)) > N_W'(63)) begin
      s0_side_nxt.bval = S_W'(63);
    end else begin
      s0_side_nxt.bval = S_W'(n_c - N_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_side_nxt;
    end
  end

  // log2 of the leaf count, a zero count reads as one
  ssc_log2 u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .x         ((leaf_r == '0) ? L_W'(1) : leaf_r),
    .in_side   (s0_side_r),
    .out_valid (lg_vld),
    .log_val   (lg_val),
    .out_side  (lg_side)
  );

  // log ratio log2(L) / log2(n)
  ssc_div #(
    .NUM_W (LG_W + 16),
    .DEN_W (LN_W),
    .QUO_W (RAT_W)
  ) u_div_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (lg_vld),
    .num       ({lg_val, 16'd0}),
    .den       (LOG2N_TAB[lg_side.n]),
    .in_side   (lg_side),
    .out_valid (d1_vld),
    .quo       (ratio),
    .out_side  (d1_side)
  );

  // scale by the request fraction, then form z and its magnitude
  always_comb begin
    logic signed [Z_W-1:0] z;
    z = $signed({{(Z_W-RAT_W){1'b0}}, sun_r})
      + $signed({mul_side_r.dz[DZ_W-1], mul_side_r.dz, 16'd0});
    z_side_nxt      = mul_side_r;
    z_side_nxt.zneg = z[Z_W-1];
    mag_nxt = z[Z_W-1] ? MAG_W'(-z) : MAG_W'(z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      z_vld_r   <= 1'b0;
      t_vld_r   <= 1'b0;
    end else if (en) begin
      mul_vld_r <= d1_vld;
      z_vld_r   <= mul_vld_r;
      t_vld_r   <= z_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [RAT_W+R_W-1:0] sp;
    logic [MAG_W+16:0]    tp;
    if (en) begin
      sp = ratio * rfrac_r;
      sun_r      <= sp[RAT_W+R_W-1:16];
      mul_side_r <= d1_side;
      mag_r      <= mag_nxt;
      z_side_r   <= z_side_nxt;
      tp = mag_r * LOG2E_Q16;
      t_r        <= tp[MAG_W+16:16];
      t_side_r   <= z_side_r;
    end
  end

  // e = 2^-t
  ssc_exp2 u_exp2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t_vld_r),
    .t         (t_r),
    .in_side   (t_side_r),
    .out_valid (ex_vld),
    .e         (ex_e),
    .out_side  (ex_side)
  );

  // q = round(2^46 / (2^30 + e))
  assign den2 = DEN_W'(32'h4000_0000) + {1'b0, ex_e};
  assign num2 = (47'd1 << 46) + {16'd0, den2[DEN_W-1:1]};

  ssc_div #(
    .NUM_W (47),
    .DEN_W (DEN_W),
    .QUO_W (Q_W)
  ) u_div_sig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ex_vld),
    .num       (num2),
    .den       (den2),
    .in_side   (ex_side),
    .out_valid (d2_vld),
    .quo       (q2),
    .out_side  (d2_side)
  );

  // scale sigma by n-1, round, saturate, merge the trivial cases
  always_comb begin
    logic [Q_W-1:0]     sig;
    logic [N_W-1:0]     nm1;
    logic [N_W+Q_W:0]   acc;
    logic [N_W+Q_W-16:0] v;
    sig = d2_side.zneg ? Q_W'(17'd65536 - q2) : q2;
    nm1 = d2_side.n - N_W'(1);
    acc = nm1 * sig + (N_W+Q_W+1)'(32768);
    v   = acc[N_W+Q_W:16];
    if (v > (N_W+Q_W-15)'(nm1)) v = (N_W+Q_W-15)'(nm1);
    if (v > (N_W+Q_W-15)'(63))  v = (N_W+Q_W-15)'(63);
    out_split_nxt = d2_side.byp ? d2_side.bval : S_W'(v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_split_r <= out_split_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.split_count = out_split_r;

endmodule

`default_nettype wire

>>> rtl/core/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for the split counter
// Watches the top-level handshakes and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker import ssc_pkg::*; (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire logic [S_W-1:0] out_split_count
);

  // input side opens exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_split_count))
    else $error("stalled result changed or dropped");

endmodule

bind sigmoid_split_count ssc_checker u_ssc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_split_count (out_ch.split_count)
);

`default_nettype wire

>>> tb/sv/tb_sigmoid_split_count.sv
// ----------------------------------------------------------------------------
// tb_sigmoid_split_count: self-checking bench for the split decision block
// Drives child count / depth items with random gaps, predicts each split
// count in fixed point, and checks results in order under random back-pressure
// across several register settings.
// ----------------------------------------------------------------------------
module tb_sigmoid_split_count;
  import ssc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [N_W-1:0] n;
    logic [D_W-1:0] d;
  } split_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssc_in_if  in_ch();
  ssc_out_if out_ch();
  ssc_cfg_if cfg_ch();

  sigmoid_split_count dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // register shadow
  logic            mode_q;
  logic [L_W-1:0]  leaves_q;
  logic [R_W-1:0]  rfrac_q;

  split_req_t       pending_q[$];
  logic [S_W-1:0]   split_expect_q[$];
  int               n_err;
  int               n_checked;
  bit               in_took;

  // isqrt by digit recurrence
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b, w;
    r = 0;
    b = 64'd1 << 62;
    w = v;
    while (b > w) b = b >> 2;
    while (b != 0) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fix(int unsigned x);
    int unsigned m;
    longint unsigned y, fr;
    m = 0;
    fr = 0;
    while (m < 30 && (x >> (m + 1)) != 0) m++;
    y = longint'(x) << (30 - m);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      fr = fr << 1;
      if (y >= (64'd1 << 31)) begin
        fr = fr | 1;
        y = y >> 1;
      end
    end
    return (longint'(m) << 16) | fr;
  endfunction

  function automatic longint unsigned pow2_neg(longint unsigned t);
    longint unsigned c, p, ip;
    c = int_sqrt(64'd1 << 59);
    p = 64'd1 << 30;
    ip = t >> 16;
    for (int k = 0; k < 16; k++) begin
      if ((t >> (15 - k)) & 1) p = (p * c) >> 30;
      c = int_sqrt(c << 30);
    end
    if (ip >= 31) return 0;
    return p >> ip;
  endfunction

  function automatic logic [S_W-1:0] predict_split(logic [N_W-1:0] n_in,
                                                   logic [D_W-1:0] d);
    int unsigned n, lv, res;
    longint unsigned ratio, sunset, mag, t, e, den, q, sig, v;
    longint z;
    n = n_in;
    if (n > MAX_CHILDREN_DEF) n = MAX_CHILDREN_DEF;
    if (n <= 1) res = 0;
    else if (mode_q) res = n - 1;
    else begin
      lv = (leaves_q == 0) ? 1 : leaves_q;
      ratio = (log2_fix(lv) << 16) / log2_fix(n);
      sunset = (ratio * longint'(rfrac_q)) >> 16;
      z = longint'(sunset) + (longint'(n) - 1 - longint'(d)) * 65536;
      mag = (z < 0) ? -z : z;
      t = (mag * 94548) >> 16;
      e = pow2_neg(t);
      den = (64'd1 << 30) + e;
      q = ((64'd1 << 46) + den / 2) / den;
      sig = (z >= 0) ? q : 65536 - q;
      v = (longint'(n - 1) * sig + 32768) >> 16;
      if (v > n - 1) v = n - 1;
      res = v;
    end
    if (res > 63) res = 63;
    return S_W'(res);
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // record input acceptance at the rising edge and predict the result
  always @(posedge clk) begin
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      split_expect_q.push_back(predict_split(in_ch.child_count, in_ch.tree_depth));
  end

  // driver: feed pending items at the falling edge
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_took) begin
        in_gap = rand_gap();
      end
      if (!in_ch.valid || in_took) begin
        if (in_gap > 0 || pending_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          split_req_t it;
          it = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.child_count <= it.n;
          in_ch.tree_depth <= it.d;
        end
      end
    end
  end

  // sink back-pressure
  int out_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = rand_gap();
    end
  end

  // monitor: check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (split_expect_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected split_count %0d", out_ch.split_count);
      end else begin
        logic [S_W-1:0] exp_v;
        exp_v = split_expect_q.pop_front();
        n_checked++;
        if (exp_v !== out_ch.split_count) begin
          n_err++;
          if (n_err <= 10)
            $display("split_count expected %0d actual %0d", exp_v, out_ch.split_count);
        end
      end
    end
  end

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_POLICY) mode_q = val[0];
    else if (idx == CFG_LEAVES) leaves_q = val[L_W-1:0];
    else if (idx == CFG_REQFRAC) rfrac_q = val[R_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int count);
    split_req_t it;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) it.n = N_W'($urandom);
      else it.n = N_W'($urandom_range(0, 66));
      if ($urandom_range(0, 1) == 0) it.d = D_W'($urandom);
      else it.d = D_W'($urandom_range(0, 80));
      pending_q.push_back(it);
    end
    while (pending_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (split_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_item(int n, int d);
    split_req_t it;
    it.n = N_W'(n);
    it.d = D_W'(d);
    pending_q.push_back(it);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.child_count = '0;
    in_ch.tree_depth = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_POLICY;
    cfg_ch.data = '0;
    mode_q = 1'b0;
    leaves_q = 20'd1;
    rfrac_q = 16'd32768;
    n_err = 0;
    n_checked = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero/one child, clamp above max, depth extremes, reset regs
    add_item(0, 0); add_item(1, 255); add_item(2, 0); add_item(2, 255);
    add_item(64, 0); add_item(64, 63); add_item(65, 0); add_item(127, 255);
    add_item(10, 9); add_item(10, 10); add_item(33, 200); add_item(3, 1);
    run_phase(0);
    cfg_write(CFG_LEAVES, 20'hFFFFF);
    cfg_write(CFG_REQFRAC, 20'hFFFF);
    add_item(2, 0); add_item(64, 255); add_item(127, 0); add_item(5, 40);
    run_phase(0);
    // zero leaves and zero fraction are both legal
    cfg_write(CFG_LEAVES, 20'd0);
    cfg_write(CFG_REQFRAC, 20'd0);
    cfg_write(3, 20'hABCDE); // out-of-range index is dropped
    add_item(20, 19); add_item(20, 0); add_item(64, 64);
    run_phase(0);
    cfg_write(CFG_POLICY, 20'd1);
    add_item(0, 0); add_item(1, 0); add_item(2, 9); add_item(64, 1); add_item(100, 7);
    run_phase(0);

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(CFG_POLICY, (ph == 3) ? 20'd1 : 20'd0);
      case (ph % 4)
        0: cfg_write(CFG_LEAVES, 20'd1);
        1: cfg_write(CFG_LEAVES, 20'hFFFFF);
        default: cfg_write(CFG_LEAVES, CFG_W'($urandom));
      endcase
      case (ph % 3)
        0: cfg_write(CFG_REQFRAC, 20'd1);
        1: cfg_write(CFG_REQFRAC, 20'hFFFF);
        default: cfg_write(CFG_REQFRAC, CFG_W'($urandom));
      endcase
      run_phase(210);
    end

    $display("checked %0d split counts over 8 random register settings", n_checked);
    $display("plus directed edge cases on child count, depth and registers");
    if (n_err == 0) begin
      $display("sigmoid_split_count: match");
    end else begin
      $display("%0d mismatches", n_err);
      $display("sigmoid_split_count: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("sigmoid_split_count: mismatch");
    $finish;
  end
endmodule
